// ----- rtl/psa_pkg.sv -----
`timescale 1ns / 1ps

package psa_pkg;

  localparam int RAM_PAGES  = 64;
  localparam int SWAP_PAGES = 64;

  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int PIDX_W = 7;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;

  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 3'd2;
  localparam logic [OP_W-1:0] OP_MOVE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX  = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_ALLOC  = 3'd2;
  localparam logic [ST_W-1:0] ST_RAM_FULL   = 3'd3;
  localparam logic [ST_W-1:0] ST_SWAP_FULL  = 3'd4;
  localparam logic [ST_W-1:0] ST_SWAP_EMPTY = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN_RAM,
    S_SCAN_SWAP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             start;
    logic             step;
    logic [IDX_W-1:0] base;
    logic [CNT_W-1:0] span;
  } scan_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic             last;
  } scan_stat_t;

endpackage

// ----- rtl/psa_scan.sv -----
`timescale 1ns / 1ps

module psa_scan (
  input  logic                clk,
  input  logic                rst,
  input  psa_pkg::scan_ctl_t  ctl,
  output psa_pkg::scan_stat_t stat
);

  logic [psa_pkg::IDX_W-1:0] pos;
  logic [psa_pkg::CNT_W-1:0] cnt;
  logic [psa_pkg::CNT_W-1:0] span;
  logic                      wrap;

  assign wrap = ({1'b0, pos} == span - psa_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      cnt  <= '0;
      span <= psa_pkg::CNT_W'(psa_pkg::RAM_PAGES);
    end else if (ctl.start) begin
      pos  <= ctl.base;
      cnt  <= '0;
      span <= ctl.span;
    end else if (ctl.step) begin
      pos <= wrap ? '0 : pos + psa_pkg::IDX_W'(1);
      cnt <= cnt + psa_pkg::CNT_W'(1);
    end
  end

  assign stat.pos  = pos;
  assign stat.last = (cnt == span - psa_pkg::CNT_W'(1));

endmodule

// ----- rtl/page_slot_allocator_with_swap_core.sv -----
`timescale 1ns / 1ps
// Free, count and checks that fail early go from S_EXEC to S_FINISH; allocate, read and move
// first visit 1 to 64 slots in S_SCAN_RAM or S_SCAN_SWAP. S_FINISH waits while a result is held.
// The allocate and read searches and the move search share one slot scanner, one slot a cycle.
// The block takes one item at a time; in_ready rises in the same cycle that the result beat appears.
// Synchronous reset marks every RAM and swap slot free and sets the search cursor to slot 0.

module page_slot_allocator_with_swap_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [psa_pkg::OP_W-1:0]    opcode,
  input  logic [psa_pkg::PIDX_W-1:0]  page_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [psa_pkg::ST_W-1:0]    status,
  output logic [psa_pkg::IDX_W-1:0]   result_index,
  output logic [psa_pkg::CNT_W-1:0]   free_count,
  output logic [psa_pkg::CNT_W-1:0]   used_count
);

  psa_pkg::state_t state, state_next;

  logic [psa_pkg::RAM_PAGES-1:0]  ram_busy, ram_busy_next;
  logic [psa_pkg::SWAP_PAGES-1:0] swap_busy, swap_busy_next;
  logic [psa_pkg::IDX_W-1:0]      cursor, cursor_next;
  logic [psa_pkg::CNT_W-1:0]      free_cnt, free_cnt_next;
  logic [psa_pkg::OP_W-1:0]       op, op_next;
  logic [psa_pkg::PIDX_W-1:0]     idx, idx_next;
  logic [psa_pkg::ST_W-1:0]       st, st_next;
  logic [psa_pkg::IDX_W-1:0]      res, res_next;
  logic                           out_valid_next;
  logic [psa_pkg::ST_W-1:0]       status_next;
  logic [psa_pkg::IDX_W-1:0]      result_index_next;
  logic [psa_pkg::CNT_W-1:0]      free_count_next;
  logic [psa_pkg::CNT_W-1:0]      used_count_next;

  psa_pkg::scan_ctl_t  scan_ctl;
  psa_pkg::scan_stat_t scan_stat;

  logic [psa_pkg::IDX_W-1:0] slot;
  logic                      ram_bad;
  logic                      swap_bad;

  assign slot     = idx[psa_pkg::IDX_W-1:0];
  assign ram_bad  = (idx >= psa_pkg::PIDX_W'(psa_pkg::RAM_PAGES));
  assign swap_bad = (idx >= psa_pkg::PIDX_W'(psa_pkg::SWAP_PAGES));
  assign in_ready = (state == psa_pkg::S_IDLE);

  psa_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctl  (scan_ctl),
    .stat (scan_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psa_pkg::S_IDLE;
      ram_busy  <= '0;
      swap_busy <= '0;
      cursor    <= '0;
      free_cnt  <= psa_pkg::CNT_W'(psa_pkg::RAM_PAGES);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ram_busy  <= ram_busy_next;
      swap_busy <= swap_busy_next;
      cursor    <= cursor_next;
      free_cnt  <= free_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op           <= op_next;
    idx          <= idx_next;
    st           <= st_next;
    res          <= res_next;
    status       <= status_next;
    result_index <= result_index_next;
    free_count   <= free_count_next;
    used_count   <= used_count_next;
  end

  always_comb begin
    state_next        = state;
    ram_busy_next     = ram_busy;
    swap_busy_next    = swap_busy;
    cursor_next       = cursor;
    free_cnt_next     = free_cnt;
    op_next           = op;
    idx_next          = idx;
    st_next           = st;
    res_next          = res;
    status_next       = status;
    result_index_next = result_index;
    free_count_next   = free_count;
    used_count_next   = used_count;
    out_valid_next    = out_valid && !out_ready;
    scan_ctl          = '0;
    scan_ctl.span     = psa_pkg::CNT_W'(psa_pkg::RAM_PAGES);

    unique case (state)
      psa_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next    = opcode;
          idx_next   = page_index;
          state_next = psa_pkg::S_EXEC;
        end
      end

      psa_pkg::S_EXEC: begin
        st_next    = psa_pkg::ST_OK;
        res_next   = '0;
        state_next = psa_pkg::S_FINISH;
        unique case (op)
          psa_pkg::OP_ALLOC: begin
            scan_ctl.start = 1'b1;
            scan_ctl.base  = cursor;
            state_next     = psa_pkg::S_SCAN_RAM;
          end
          psa_pkg::OP_FREE: begin
            if (ram_bad) begin
              st_next = psa_pkg::ST_BAD_INDEX;
            end else if (!ram_busy[slot]) begin
              st_next = psa_pkg::ST_NOT_ALLOC;
            end else begin
              ram_busy_next[slot] = 1'b0;
              free_cnt_next       = free_cnt + psa_pkg::CNT_W'(1);
              res_next            = slot;
            end
          end
          psa_pkg::OP_MOVE: begin
            if (ram_bad) begin
              st_next = psa_pkg::ST_BAD_INDEX;
            end else if (!ram_busy[slot]) begin
              st_next = psa_pkg::ST_NOT_ALLOC;
            end else begin
              scan_ctl.start = 1'b1;
              scan_ctl.base  = '0;
              scan_ctl.span  = psa_pkg::CNT_W'(psa_pkg::SWAP_PAGES);
              state_next     = psa_pkg::S_SCAN_SWAP;
            end
          end
          psa_pkg::OP_READ: begin
            if (swap_bad) begin
              st_next = psa_pkg::ST_BAD_INDEX;
            end else begin
              scan_ctl.start = 1'b1;
              scan_ctl.base  = cursor;
              state_next     = psa_pkg::S_SCAN_RAM;
            end
          end
          default: begin
          end
        endcase
      end

      psa_pkg::S_SCAN_RAM: begin
        if (!ram_busy[scan_stat.pos]) begin
          cursor_next = scan_stat.pos;
          state_next  = psa_pkg::S_FINISH;
          if (op == psa_pkg::OP_READ && !swap_busy[slot]) begin
            st_next = psa_pkg::ST_SWAP_EMPTY;
          end else begin
            if (op == psa_pkg::OP_READ) begin
              swap_busy_next[slot] = 1'b0;
            end
            ram_busy_next[scan_stat.pos] = 1'b1;
            free_cnt_next                = free_cnt - psa_pkg::CNT_W'(1);
            res_next                     = scan_stat.pos;
          end
        end else if (scan_stat.last) begin
          st_next    = psa_pkg::ST_RAM_FULL;
          state_next = psa_pkg::S_FINISH;
        end else begin
          scan_ctl.step = 1'b1;
        end
      end

      psa_pkg::S_SCAN_SWAP: begin
        if (!swap_busy[scan_stat.pos]) begin
          swap_busy_next[scan_stat.pos] = 1'b1;
          ram_busy_next[slot]           = 1'b0;
          free_cnt_next                 = free_cnt + psa_pkg::CNT_W'(1);
          res_next                      = scan_stat.pos;
          state_next                    = psa_pkg::S_FINISH;
        end else if (scan_stat.last) begin
          st_next    = psa_pkg::ST_SWAP_FULL;
          state_next = psa_pkg::S_FINISH;
        end else begin
          scan_ctl.step = 1'b1;
        end
      end

      psa_pkg::S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next    = 1'b1;
          status_next       = st;
          result_index_next = res;
          free_count_next   = free_cnt;
          used_count_next   = psa_pkg::CNT_W'(psa_pkg::RAM_PAGES) - free_cnt;
          state_next        = psa_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = psa_pkg::S_IDLE;
      end
    endcase
  end

  a_free_cnt_tracks_map: assert property (@(posedge clk) disable iff (rst)
    (free_cnt + psa_pkg::CNT_W'($countones(ram_busy))) == psa_pkg::CNT_W'(psa_pkg::RAM_PAGES))
    else $error("free slot count disagrees with the RAM occupancy map");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cursor} < psa_pkg::CNT_W'(psa_pkg::RAM_PAGES))
    else $error("search cursor outside the RAM slot range");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == psa_pkg::S_FINISH)
    else $error("result beat raised outside the finish state");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == psa_pkg::S_SCAN_RAM |-> {1'b0, scan_stat.pos} < psa_pkg::CNT_W'(psa_pkg::RAM_PAGES))
    else $error("RAM scan position outside the slot range");

endmodule
